>>> rtl/ifp_pkg.sv
// Shared types and constants for the image frame packer.
package ifp_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned DimW      = 8;
  localparam int unsigned PosW      = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned NumSlots  = 9;
  localparam int unsigned SlotW     = 4;

  localparam logic [CfgIdxW-1:0] CfgHeight = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFormat = 2'd2;

  localparam logic FmtGray   = 1'b0;
  localparam logic FmtBinary = 1'b1;

  localparam logic [SlotW-1:0] SlotData  = 4'd4;
  localparam logic [SlotW-1:0] SlotFinal = 4'd8;

  localparam logic [ByteW-1:0] HeadOuter = 8'ha0;
  localparam logic [ByteW-1:0] HeadInner = 8'hff;
  localparam logic [ByteW-1:0] TailMark  = 8'hb0;
  localparam logic [ByteW-1:0] TailLf    = 8'h0a;
  localparam logic [ByteW-1:0] TailCr    = 8'h0d;

  typedef struct packed {
    logic             hdr;
    logic             data_vld;
    logic [ByteW-1:0] data;
    logic             tail;
  } job_t;

endpackage

>>> rtl/ifp_front.sv
// Front end: tracks frame position, packs binary pixels and classifies each request.
module ifp_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ifp_pkg::DimW-1:0]   image_height_i,
  input  logic [ifp_pkg::DimW-1:0]   image_width_i,
  input  logic                       pixel_format_i,
  input  logic                       pixel_valid_i,
  output logic                       pixel_ready_o,
  input  logic [ifp_pkg::ByteW-1:0]  pixel_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output ifp_pkg::job_t              q_job_o
);

  logic [ifp_pkg::PosW-1:0]  pos_q, pos_d;
  logic [ifp_pkg::ByteW-1:0] acc_q, acc_d;
  logic [ifp_pkg::PosW-1:0]  total;
  logic [ifp_pkg::PosW:0]    pos_inc;
  logic                      last;
  logic                      accept;
  logic [ifp_pkg::ByteW-1:0] acc_new;
  logic                      group_done;

  assign pixel_ready_o = !q_full_i;
  assign accept        = pixel_valid_i && pixel_ready_o;

  assign total      = ifp_pkg::PosW'(image_height_i) * ifp_pkg::PosW'(image_width_i);
  assign pos_inc    = {1'b0, pos_q} + {{ifp_pkg::PosW{1'b0}}, 1'b1};
  assign last       = pos_inc >= {1'b0, total};
  assign group_done = (pos_q[2:0] == 3'd7);
  assign acc_new    = (pixel_i != '0) ? (acc_q | (8'h80 >> pos_q[2:0])) : acc_q;

  always_comb begin
    q_job_o.hdr = (pos_q == '0);
    q_job_o.tail = last;
    if (pixel_format_i == ifp_pkg::FmtGray) begin
      q_job_o.data_vld = 1'b1;
      q_job_o.data     = pixel_i;
    end else begin
      q_job_o.data_vld = group_done;
      q_job_o.data     = acc_new;
    end
  end

  assign q_push_o = accept && (q_job_o.hdr || q_job_o.data_vld || q_job_o.tail);

  always_comb begin
    pos_d = pos_q;
    acc_d = acc_q;
    if (accept) begin
      if (last) begin
        pos_d = '0;
        acc_d = '0;
      end else begin
        pos_d = pos_inc[ifp_pkg::PosW-1:0];
        if (pixel_format_i == ifp_pkg::FmtBinary) begin
          acc_d = group_done ? '0 : acc_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      acc_q <= '0;
    end else begin
      pos_q <= pos_d;
      acc_q <= acc_d;
    end
  end

endmodule

>>> rtl/ifp_queue.sv
// Small request queue between front and back ends.
module ifp_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ifp_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output ifp_pkg::job_t head_job_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  ifp_pkg::job_t      mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

>>> rtl/ifp_back.sv
// Back end: expands each request into header, data and trailer bytes.
module ifp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  ifp_pkg::job_t             head_job_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ifp_pkg::ByteW-1:0] out_byte_o,
  output logic                      run_end_o,
  output logic                      frame_end_o
);

  logic [ifp_pkg::NumSlots-1:0] rem_q, rem_d;
  logic                         started_q, started_d;
  logic [ifp_pkg::NumSlots-1:0] full_mask, cur_mask, rest_mask;
  logic [ifp_pkg::SlotW-1:0]    slot;
  logic [ifp_pkg::ByteW-1:0]    slot_byte;
  logic                         advance, emit, job_done;

  logic                         out_valid_q, out_valid_d;
  logic [ifp_pkg::ByteW-1:0]    out_byte_q, out_byte_d;
  logic                         run_end_q, run_end_d;
  logic                         frame_end_q, frame_end_d;

  assign full_mask = {{4{head_job_i.tail}}, head_job_i.data_vld, {4{head_job_i.hdr}}};
  assign cur_mask  = started_q ? rem_q : full_mask;

  always_comb begin
    slot = ifp_pkg::SlotFinal;
    for (int i = ifp_pkg::NumSlots - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        slot = ifp_pkg::SlotW'(i);
      end
    end
  end

  always_comb begin
    rest_mask       = cur_mask;
    rest_mask[slot] = 1'b0;
  end

  always_comb begin
    case (slot)
      4'd0, 4'd3:         slot_byte = ifp_pkg::HeadOuter;
      4'd1, 4'd2:         slot_byte = ifp_pkg::HeadInner;
      ifp_pkg::SlotData:  slot_byte = head_job_i.data;
      4'd5, 4'd6:         slot_byte = ifp_pkg::TailMark;
      4'd7:               slot_byte = ifp_pkg::TailLf;
      ifp_pkg::SlotFinal: slot_byte = ifp_pkg::TailCr;
      default:            slot_byte = ifp_pkg::TailCr;
    endcase
  end

  assign advance  = !out_valid_q || out_ready_i;
  assign emit     = advance && head_valid_i;
  assign job_done = (rest_mask == '0);
  assign pop_o    = emit && job_done;

  always_comb begin
    rem_d       = rem_q;
    started_d   = started_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    run_end_d   = run_end_q;
    frame_end_d = frame_end_q;
    if (advance) begin
      out_valid_d = head_valid_i;
    end
    if (emit) begin
      out_byte_d  = slot_byte;
      run_end_d   = job_done;
      frame_end_d = (slot == ifp_pkg::SlotFinal);
      rem_d       = rest_mask;
      started_d   = !job_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    out_byte_q  <= out_byte_d;
    run_end_q   <= run_end_d;
    frame_end_q <= frame_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_end_o   = run_end_q;
  assign frame_end_o = frame_end_q;

endmodule

>>> rtl/image_frame_packer.sv
// Top level of the image frame packer: configuration registers and block wiring.
//
// Pixels enter on the pixel channel (pixel_valid_i/pixel_ready_o/pixel_i) in
// raster order; framed bytes leave on the out channel (out_valid_o/out_ready_i)
// with run_end_o on the last byte a pixel causes and frame_end_o on the final
// trailer byte. The first pixel of a frame is preceded by A0 FF FF A0, the last
// one is followed by B0 B0 0A 0D. Gray mode passes each pixel as a byte; binary
// mode packs eight pixels MSB first and drops a final partial byte.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 height, 1 width, 2 format); write only while the block is idle.
// Requests wait in a queue; the back end registers each byte. Throughput: one
// pixel per cycle while the queue has room; the back end sends one byte per
// cycle while out_ready_i allows, so frame edges (up to nine bytes for one
// pixel) fill the request queue of QueueDepth entries and pause pixel_ready_o
// until an entry frees. Reset clears position, pack bits, queue and output
// valid; height and width return to 1, format to gray. A stalled receiver
// holds the output byte and backs up through the queue to the pixel channel.
module image_frame_packer #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ifp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ifp_pkg::DimW-1:0]    cfg_data_i,
  input  logic                        pixel_valid_i,
  output logic                        pixel_ready_o,
  input  logic [ifp_pkg::ByteW-1:0]   pixel_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ifp_pkg::ByteW-1:0]   out_byte_o,
  output logic                        run_end_o,
  output logic                        frame_end_o
);

  logic [ifp_pkg::DimW-1:0] image_height_q;
  logic [ifp_pkg::DimW-1:0] image_width_q;
  logic                     pixel_format_q;

  logic          q_full, q_push, q_pop, q_head_valid;
  ifp_pkg::job_t q_push_job, q_head_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_height_q <= 8'd1;
      image_width_q  <= 8'd1;
      pixel_format_q <= ifp_pkg::FmtGray;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ifp_pkg::CfgHeight: image_height_q <= cfg_data_i;
        ifp_pkg::CfgWidth:  image_width_q  <= cfg_data_i;
        ifp_pkg::CfgFormat: pixel_format_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ifp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_height_i (image_height_q),
    .image_width_i  (image_width_q),
    .pixel_format_i (pixel_format_q),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_ready_o  (pixel_ready_o),
    .pixel_i        (pixel_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_job_o        (q_push_job)
  );

  ifp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_job_i   (q_push_job),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_job_o   (q_head_job)
  );

  ifp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_head_valid),
    .head_job_i   (q_head_job),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_end_o    (run_end_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

>>> test/image_frame_packer_tb.sv
// Testbench for the image frame packer: directed and random pixel streams checked byte by byte.
module image_frame_packer_tb;

  localparam logic [ifp_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned MaxReports = 50;

  typedef struct packed {
    logic [ifp_pkg::ByteW-1:0] value;
    logic                      run_end;
    logic                      frame_end;
  } byte_result_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [ifp_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [ifp_pkg::DimW-1:0]    cfg_data_i = '0;
  logic                        pixel_valid_i = 1'b0;
  logic                        pixel_ready_o;
  logic [ifp_pkg::ByteW-1:0]   pixel_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [ifp_pkg::ByteW-1:0]   out_byte_o;
  logic                        run_end_o;
  logic                        frame_end_o;

  image_frame_packer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_i       (pixel_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_end_o     (run_end_o),
    .frame_end_o   (frame_end_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state
  logic [ifp_pkg::DimW-1:0]  img_height = 8'd1;
  logic [ifp_pkg::DimW-1:0]  img_width = 8'd1;
  logic                      img_format = ifp_pkg::FmtGray;
  logic [ifp_pkg::PosW-1:0]  pixel_pos = '0;
  logic [ifp_pkg::ByteW-1:0] pack_bits = '0;

  byte_result_t expected_bytes[$];
  byte_result_t got_byte;
  byte_result_t want_byte;
  int unsigned  mismatch_count = 0;
  int unsigned  send_idle_pct = 7;
  int unsigned  recv_idle_pct = 58;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MaxReports) begin
      $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic void predict_pixel(input logic [ifp_pkg::ByteW-1:0] px);
    byte_result_t run[$];
    int unsigned  total;
    int unsigned  bit_idx;
    logic         frame_done;
    total = 32'(img_height) * 32'(img_width);
    frame_done = (32'(pixel_pos) + 1) >= total;
    if (pixel_pos == 0) begin
      run.push_back({ifp_pkg::HeadOuter, 2'b00});
      run.push_back({ifp_pkg::HeadInner, 2'b00});
      run.push_back({ifp_pkg::HeadInner, 2'b00});
      run.push_back({ifp_pkg::HeadOuter, 2'b00});
    end
    if (img_format == ifp_pkg::FmtGray) begin
      run.push_back({px, 2'b00});
    end else begin
      bit_idx = 32'(pixel_pos[2:0]);
      if (px != 0) pack_bits[7 - bit_idx] = 1'b1;
      if (bit_idx == 7) begin
        run.push_back({pack_bits, 2'b00});
        pack_bits = '0;
      end
    end
    if (frame_done) begin
      run.push_back({ifp_pkg::TailMark, 2'b00});
      run.push_back({ifp_pkg::TailMark, 2'b00});
      run.push_back({ifp_pkg::TailLf, 2'b00});
      run.push_back({ifp_pkg::TailCr, 2'b00});
      run[run.size()-1].frame_end = 1'b1;
      pixel_pos = '0;
      pack_bits = '0;
    end else begin
      pixel_pos = pixel_pos + 1'b1;
    end
    if (run.size() > 0) run[run.size()-1].run_end = 1'b1;
    foreach (run[i]) expected_bytes.push_back(run[i]);
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_byte = {out_byte_o, run_end_o, frame_end_o};
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected byte", got_byte.value, 0);
      end else begin
        want_byte = expected_bytes.pop_front();
        if (got_byte.value !== want_byte.value)
          report_mismatch("out_byte", got_byte.value, want_byte.value);
        if (got_byte.run_end !== want_byte.run_end)
          report_mismatch("run_end", got_byte.run_end, want_byte.run_end);
        if (got_byte.frame_end !== want_byte.frame_end)
          report_mismatch("frame_end", got_byte.frame_end, want_byte.frame_end);
      end
    end
  end

  task automatic send_pixel(input logic [ifp_pkg::ByteW-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    pixel_i <= px;
    do @(posedge clk_i); while (!pixel_ready_o);
    predict_pixel(px);
  endtask

  // Hold off requests until every expected byte is out, then let the pipeline settle.
  task automatic wait_idle();
    pixel_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ifp_pkg::CfgIdxW-1:0] idx,
                           input logic [ifp_pkg::DimW-1:0] data);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      ifp_pkg::CfgHeight: img_height = data;
      ifp_pkg::CfgWidth:  img_width = data;
      ifp_pkg::CfgFormat: img_format = data[0];
      default: ;
    endcase
  endtask

  task automatic test_default_config();
    send_pixel(8'h00);
    send_pixel(8'hff);
  endtask

  task automatic test_gray_frame();
    write_reg(ifp_pkg::CfgHeight, 8'd2);
    write_reg(ifp_pkg::CfgWidth, 8'd1);
    send_pixel(8'h55);
    send_pixel(8'haa);
  endtask

  // One full packed byte, then a lone pixel that is dropped at frame end.
  task automatic test_binary_packing();
    write_reg(ifp_pkg::CfgHeight, 8'd1);
    write_reg(ifp_pkg::CfgWidth, 8'd9);
    write_reg(ifp_pkg::CfgFormat, {7'd0, ifp_pkg::FmtBinary});
    send_pixel(8'h01);
    send_pixel(8'h00);
    send_pixel(8'hff);
    send_pixel(8'h00);
    send_pixel(8'h00);
    send_pixel(8'h80);
    send_pixel(8'h00);
    send_pixel(8'h10);
    send_pixel(8'h7f);
  endtask

  task automatic test_zero_dimension();
    write_reg(ifp_pkg::CfgHeight, 8'd0);
    send_pixel(8'hff);
    write_reg(ifp_pkg::CfgFormat, {7'd0, ifp_pkg::FmtGray});
    send_pixel(8'h3c);
    write_reg(ifp_pkg::CfgHeight, 8'd1);
    write_reg(ifp_pkg::CfgWidth, 8'd0);
    send_pixel(8'hc3);
  endtask

  task automatic test_midframe_config();
    write_reg(ifp_pkg::CfgHeight, 8'd255);
    write_reg(ifp_pkg::CfgWidth, 8'd255);
    send_pixel(8'h12);
    send_pixel(8'h34);
    write_reg(ifp_pkg::CfgFormat, {7'd0, ifp_pkg::FmtBinary});
    send_pixel(8'hff);
    send_pixel(8'h00);
    send_pixel(8'h01);
    send_pixel(8'h40);
    send_pixel(8'h20);
    send_pixel(8'h00);
    send_pixel(8'h04);
    // switch to gray and back with pack bits pending
    write_reg(ifp_pkg::CfgFormat, {7'd0, ifp_pkg::FmtGray});
    send_pixel(8'hc3);
    write_reg(ifp_pkg::CfgFormat, {7'd0, ifp_pkg::FmtBinary});
    // shrink below the current position: the next pixel ends the frame
    write_reg(ifp_pkg::CfgHeight, 8'd1);
    write_reg(ifp_pkg::CfgWidth, 8'd1);
    send_pixel(8'h08);
    write_reg(CfgUnused, 8'h5a);
    send_pixel(8'h01);
  endtask

  function automatic logic [ifp_pkg::ByteW-1:0] random_pixel();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic test_random_traffic(input int unsigned sender_idle,
                                     input int unsigned recv_idle,
                                     input int unsigned num_pixels);
    int unsigned sent;
    int unsigned total;
    int unsigned remaining;
    logic        fmt;
    logic [ifp_pkg::DimW-1:0] h;
    logic [ifp_pkg::DimW-1:0] w;
    send_idle_pct = sender_idle;
    recv_idle_pct = recv_idle;
    sent = 0;
    while (sent < num_pixels) begin
      fmt = 1'($urandom_range(1));
      h = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
      if (fmt == ifp_pkg::FmtBinary && $urandom_range(1) == 1) w = 8'd8;
      else w = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 10));
      write_reg(ifp_pkg::CfgHeight, h);
      write_reg(ifp_pkg::CfgWidth, w);
      write_reg(ifp_pkg::CfgFormat, {7'($urandom_range(127)), fmt});
      total = 32'(h) * 32'(w);
      remaining = (total > 32'(pixel_pos)) ? total - 32'(pixel_pos) : 1;
      if ($urandom_range(5) == 0) remaining = $urandom_range(1, remaining);
      if (remaining > num_pixels - sent) remaining = num_pixels - sent;
      repeat (remaining) begin
        send_pixel(random_pixel());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_config();
    test_gray_frame();
    test_binary_packing();
    test_zero_dimension();
    test_midframe_config();
    test_random_traffic(7, 58, 32);
    test_random_traffic(58, 7, 32);
    test_random_traffic(0, 0, 32);
    wait_idle();
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> image_frame_packer.f
rtl/ifp_pkg.sv
rtl/ifp_front.sv
rtl/ifp_queue.sv
rtl/ifp_back.sv
rtl/image_frame_packer.sv
test/image_frame_packer_tb.sv
